// File: sv/kpld_pkg.sv
// Package for the key press and long-press detector.
// Holds field widths, register indexes, reset values, default parameters
// and the command and status structs shared by the controller and datapath.
`default_nettype none

package kpld_pkg;

  // Field widths
  localparam int KEY_W      = 8;
  localparam int CNT_W      = 16;
  localparam int LONG_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_TIME = 1'd1;

  // Register reset values
  localparam logic [LONG_W-1:0] LONG_TIME_RST  = 8'd100;
  localparam logic [CNT_W-1:0]  COMBO_TIME_RST = 16'd300;

  // Default parameter values
  localparam int KEY_COUNT_DEF      = 8;
  localparam int COMBO_HOLD_DEF     = 200;
  localparam int PARTNER_OFFSET_DEF = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // a request is accepted: sample and latch keys
    logic step;     // visit the current key counter
    logic publish;  // copy the tick result into the output register
  } kpld_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_key;  // the key being visited is the last one
  } kpld_stat_t;

endpackage

`default_nettype wire

// File: sv/kpld_if.sv
// Channel interfaces for the key press and long-press detector.
// Depends on kpld_pkg for the field widths.
`default_nettype none

interface kpld_in_if;
  import kpld_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_sample;
  logic [KEY_W-1:0]  clear_mask;

  modport source (output valid, output key_sample, output clear_mask, input ready);
  modport sink   (input valid, input key_sample, input clear_mask, output ready);
endinterface

interface kpld_out_if;
  import kpld_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  held_keys;
  logic [KEY_W-1:0]  press_edges;
  logic [KEY_W-1:0]  press_latched;
  logic [KEY_W-1:0]  long_flags;
  logic              combo_active;

  modport source (output valid, output held_keys, output press_edges,
                  output press_latched, output long_flags, output combo_active,
                  input ready);
  modport sink   (input valid, input held_keys, input press_edges,
                  input press_latched, input long_flags, input combo_active,
                  output ready);
endinterface

`default_nettype wire

// File: sv/kpld_ctrl.sv
// Controller of the key press and long-press detector.
// Sequences one request through the key counter visits; uses kpld_pkg.
`default_nettype none

module kpld_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      kpld_pkg::kpld_cmd_t cmd,
  input  wire kpld_pkg::kpld_stat_t stat
);
  import kpld_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // Commands follow the state and the handshakes directly.
  always_comb begin
    in_ready        = (state == ST_IDLE);
    cmd.load        = in_valid && in_ready;
    cmd.step        = (state == ST_RUN);
    cmd.publish     = (state == ST_DONE) && (!out_valid || out_ready);
  end

  // Next state and output valid.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.last_key) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cmd.publish) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/kpld_dp.sv
// Datapath of the key press and long-press detector.
// Holds samples, flags, the hold counters and the output register; uses kpld_pkg.
`default_nettype none

module kpld_dp #(
  parameter int KEY_COUNT      = kpld_pkg::KEY_COUNT_DEF,
  parameter int COMBO_HOLD     = kpld_pkg::COMBO_HOLD_DEF,
  parameter int PARTNER_OFFSET = kpld_pkg::PARTNER_OFFSET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire kpld_pkg::kpld_cmd_t             cmd,
  output      kpld_pkg::kpld_stat_t            stat,
  input  wire logic                            cfg_we,
  input  wire logic [kpld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpld_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [kpld_pkg::KEY_W-1:0]      key_sample,
  input  wire logic [kpld_pkg::KEY_W-1:0]      clear_mask,
  output      logic [kpld_pkg::KEY_W-1:0]      held_keys,
  output      logic [kpld_pkg::KEY_W-1:0]      press_edges,
  output      logic [kpld_pkg::KEY_W-1:0]      press_latched,
  output      logic [kpld_pkg::KEY_W-1:0]      long_flags,
  output      logic                            combo_active
);
  import kpld_pkg::*;

  localparam int IW         = $clog2(KEY_COUNT);
  localparam int MW         = $clog2(KEY_COUNT + PARTNER_OFFSET);
  localparam bit PARTNER_OK = (PARTNER_OFFSET < KEY_COUNT);
  localparam int P_IDX      = PARTNER_OK ? PARTNER_OFFSET : 0;
  localparam logic [IW-1:0]    PARTNER_IX = IW'(P_IDX);
  localparam logic [IW-1:0]    LAST_IX    = IW'(KEY_COUNT - 1);
  localparam logic [CNT_W-1:0] HOLD_CLAMP = CNT_W'(COMBO_HOLD);

  // Configuration registers
  logic [LONG_W-1:0] long_time;
  logic [CNT_W-1:0]  combo_time;

  // Tick state
  logic [KEY_W-1:0]  last_sample;
  logic [KEY_W-1:0]  older_sample;
  logic [KEY_W-1:0]  press_sticky;
  logic [KEY_W-1:0]  long_pending;
  logic [KEY_W-1:0]  held;
  logic [KEY_W-1:0]  edges;
  logic              combo_mode;
  logic [CNT_W-1:0]  hold_count [KEY_COUNT];
  logic [IW-1:0]     idx;

  // Next values of one key visit
  logic [CNT_W-1:0]  hold_count_next [KEY_COUNT];
  logic [KEY_W-1:0]  long_pending_next;
  logic              combo_mode_next;
  logic              held_bit;
  logic [CNT_W-1:0]  inc;
  logic [CNT_W-1:0]  cnt_first;
  logic [CNT_W-1:0]  cnt_partner;
  logic [CNT_W-1:0]  visit_val;
  logic              combo_start;
  logic              combo_now;
  logic              combo_fire;
  logic              long_hit;
  logic [MW-1:0]     mate;
  logic              mate_ok;
  logic [KEY_W-1:0]  held_in;

  assign stat.last_key = (idx == LAST_IX);
  assign held_in       = ~last_sample & ~key_sample;

  // One key visit: shared increment, combination check and compares.
  always_comb begin
    hold_count_next   = hold_count;
    long_pending_next = long_pending;
    combo_mode_next   = combo_mode;
    held_bit    = held[idx];
    inc         = hold_count[idx] + 1'b1;
    cnt_first   = (idx == '0) ? inc : hold_count[0];
    cnt_partner = (idx == PARTNER_IX) ? inc : hold_count[PARTNER_IX];
    combo_start = held_bit && !combo_mode && PARTNER_OK &&
                  (cnt_first > HOLD_CLAMP) && (cnt_partner > HOLD_CLAMP);
    visit_val   = (combo_start && ((idx == '0) || (idx == PARTNER_IX))) ?
                  HOLD_CLAMP : inc;
    combo_now   = combo_mode || combo_start;
    combo_fire  = held_bit && combo_now && (visit_val == combo_time);
    long_hit    = held_bit && !combo_now &&
                  (visit_val == {{(CNT_W-LONG_W){1'b0}}, long_time});
    mate        = MW'(idx) + MW'(PARTNER_OFFSET);
    mate_ok     = (mate < MW'(KEY_COUNT));

    if (!held_bit) begin
      hold_count_next[idx] = '0;
    end else begin
      hold_count_next[idx] = visit_val;
      if (combo_start) begin
        hold_count_next[0]          = HOLD_CLAMP;
        hold_count_next[PARTNER_IX] = HOLD_CLAMP;
      end
      combo_mode_next = combo_now;
      if (combo_fire) begin
        hold_count_next[idx] = '0;
        if (mate_ok) begin
          hold_count_next[mate[IW-1:0]] = '0;
        end
        long_pending_next = long_pending | (KEY_W'(1) << idx) | (KEY_W'(2) << idx);
        combo_mode_next   = 1'b0;
      end
      if (long_hit) begin
        long_pending_next = long_pending | (KEY_W'(1) << idx);
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_time  <= LONG_TIME_RST;
      combo_time <= COMBO_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_TIME:  long_time  <= cfg_data[LONG_W-1:0];
        REG_COMBO_TIME: combo_time <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sampling on an accepted request, then one counter visit per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample  <= '1;
      older_sample <= '1;
      press_sticky <= '0;
      long_pending <= '0;
      combo_mode   <= 1'b0;
      idx          <= '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        hold_count[k] <= '0;
      end
    end else if (cmd.load) begin
      long_pending <= long_pending & ~clear_mask;
      press_sticky <= press_sticky | (held_in & older_sample);
      older_sample <= last_sample;
      last_sample  <= key_sample;
      idx          <= '0;
    end else if (cmd.step) begin
      hold_count   <= hold_count_next;
      long_pending <= long_pending_next;
      combo_mode   <= combo_mode_next;
      idx          <= idx + 1'b1;
    end
  end

  // Held and edge bits of the current tick.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held  <= held_in;
      edges <= held_in & older_sample;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      held_keys     <= held;
      press_edges   <= edges;
      press_latched <= press_sticky;
      long_flags    <= long_pending;
      combo_active  <= combo_mode;
    end
  end

endmodule

`default_nettype wire

// File: sv/key_press_long_press_detector_unit.sv
// Top level of the key press and long-press detector.
// Depends on kpld_pkg, kpld_if, kpld_ctrl and kpld_dp.
//
// One request is one scan tick: an active-low key sample and a mask of
// long-press flags to clear. The block samples the keys in the accept cycle,
// then visits the hold counters one key per cycle through a single shared
// increment and compare unit, and hands the result to the output register
// from the done state, which waits while an earlier result is still
// offered. No new request is taken before that hand-over. A finished result
// waits in the output register while the next request is taken.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0
// is long_time, index 1 is combo_time.
`default_nettype none

module key_press_long_press_detector_unit #(
  parameter int KEY_COUNT      = kpld_pkg::KEY_COUNT_DEF,
  parameter int COMBO_HOLD     = kpld_pkg::COMBO_HOLD_DEF,
  parameter int PARTNER_OFFSET = kpld_pkg::PARTNER_OFFSET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  kpld_in_if.sink                              in_ch,
  kpld_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [kpld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpld_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kpld_pkg::*;

  kpld_cmd_t  cmd;
  kpld_stat_t stat;

  // Sequencer
  kpld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Key state and counters
  kpld_dp #(
    .KEY_COUNT      (KEY_COUNT),
    .COMBO_HOLD     (COMBO_HOLD),
    .PARTNER_OFFSET (PARTNER_OFFSET)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .key_sample    (in_ch.key_sample),
    .clear_mask    (in_ch.clear_mask),
    .held_keys     (out_ch.held_keys),
    .press_edges   (out_ch.press_edges),
    .press_latched (out_ch.press_latched),
    .long_flags    (out_ch.long_flags),
    .combo_active  (out_ch.combo_active)
  );

endmodule

`default_nettype wire

// File: sv/kpld_checker.sv
// Port-level checker for the key press and long-press detector.
// Bound to key_press_long_press_detector_unit; uses kpld_pkg widths.
`default_nettype none

module kpld_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [kpld_pkg::KEY_W-1:0] held_keys,
  input wire logic [kpld_pkg::KEY_W-1:0] press_edges,
  input wire logic [kpld_pkg::KEY_W-1:0] press_latched
);
  import kpld_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Each request is worked on alone: no request is taken right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in work");

  // An edge is only raised on a held key.
  a_edge_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_edges & ~held_keys) == '0))
    else $error("press edge on a key that is not held");

  // Every run of holding starts with an edge, so held keys are latched.
  a_held_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((held_keys & ~press_latched) == '0))
    else $error("held key missing from the press record");

endmodule

bind key_press_long_press_detector_unit kpld_checker u_kpld_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .held_keys     (out_ch.held_keys),
  .press_edges   (out_ch.press_edges),
  .press_latched (out_ch.press_latched)
);

`default_nettype wire
